FILE: hdl/swe_pkg.sv
// Shared types and constants of the stack word evaluator.
`timescale 1ns / 1ps
package swe_pkg;

  localparam int unsigned StackDepthDefault = 64;
  localparam int unsigned DataDepthDefault  = 1024;

  typedef enum logic [3:0] {
    ACT_PUSH_VAL = 4'd0,
    ACT_PUSH_VAR = 4'd1,
    ACT_NEG      = 4'd2,
    ACT_ADD      = 4'd3,
    ACT_SUB      = 4'd4,
    ACT_MUL      = 4'd5,
    ACT_DIV      = 4'd6,
    ACT_REM      = 4'd7,
    ACT_STORE    = 4'd8,
    ACT_FETCH    = 4'd9,
    ACT_LESS     = 4'd10,
    ACT_EQUAL    = 4'd11,
    ACT_GREATER  = 4'd12,
    ACT_POP      = 4'd13,
    ACT_NOP14    = 4'd14,
    ACT_NOP15    = 4'd15
  } action_e;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_OVER  = 3'd1,
    ERR_UNDER = 3'd2,
    ERR_DIVZ  = 3'd3,
    ERR_REMZ  = 3'd4,
    ERR_ADDR  = 3'd5
  } err_e;

  typedef struct packed {
    logic [3:0]  action;
    logic signed [31:0] value;
    logic [4:0]  letter;
    logic [9:0]  frame_offset;
  } token_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic        popped_valid;
    logic [2:0]  error_code;
    logic [6:0]  stack_depth;
  } result_t;

endpackage

FILE: hdl/swe_token_if.sv
// Valid/ready channel that carries one decoded token.
`timescale 1ns / 1ps
interface swe_token_if import swe_pkg::*; ();
  logic   valid;
  logic   ready;
  token_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/swe_result_if.sv
// Valid/ready channel that carries one result item.
`timescale 1ns / 1ps
interface swe_result_if import swe_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/swe_ram.sv
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
module swe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: hdl/swe_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module swe_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [31:0] rem_o
);
  logic [31:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic        qneg_q, qneg_d, rneg_q, rneg_d;
  logic [32:0] trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; dvs_d = dvs_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0; qneg_d = qneg_q; rneg_d = rneg_q;
    trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      rem_d  = 32'd0;
      quo_d  = dividend_i[31] ? 32'd0 - dividend_i : dividend_i;
      dvs_d  = divisor_i[31] ? 32'd0 - divisor_i : divisor_i;
      qneg_d = dividend_i[31] ^ divisor_i[31];
      rneg_d = dividend_i[31];
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    qneg_q <= qneg_d;
    rneg_q <= rneg_d;
  end

  assign done_o = done_q;
  assign quot_o = qneg_q ? 32'd0 - quo_q : quo_q;
  assign rem_o  = rneg_q ? 32'd0 - rem_q : rem_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q && !start_i |=> cnt_q == $past(cnt_q)) else $error("divider count moved");
  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(start_i)) else $error("divider busy without start");
endmodule

FILE: hdl/stack_word_evaluator_top.sv
// Top level of the stack word evaluator: control sequencer, stack and data memories.
// Each token is accepted, then takes two stack reads, execute and result; fetch adds a
// data memory read, and div and rem run through the bit-serial divider after execute.
// Throughput: one token at a time; the next is accepted once the result is taken.
// Reset clears the stack count, then sweeps data memory to zero, address by address;
// no token is accepted during the sweep. Stack memory contents are not cleared.
`timescale 1ns / 1ps
module stack_word_evaluator_top import swe_pkg::*; #(
  parameter int unsigned STACK_DEPTH = StackDepthDefault,
  parameter int unsigned DATA_DEPTH  = DataDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  swe_token_if.sink    token_i,
  swe_result_if.source result_o
);
  localparam int unsigned SaW = $clog2(STACK_DEPTH);
  localparam int unsigned DaW = $clog2(DATA_DEPTH);
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_TOP, S_RD_SEC, S_EXEC, S_DIV, S_FETCH, S_DONE
  } state_e;

  state_e       state_q;
  logic [DaW:0] clr_q;
  token_t       tok_q;
  logic [CntW-1:0] cnt_q;
  logic [31:0]  top_q;
  logic         res_valid_q;
  result_t      res_q;

  logic            s_we;
  logic [SaW-1:0]  s_addr;
  logic [31:0]     s_wdata, s_rdata;
  logic            d_we;
  logic [DaW-1:0]  d_addr;
  logic [31:0]     d_wdata, d_rdata;
  logic            div_start, div_done;
  logic [31:0]     div_q, div_r;

  swe_ram #(.Width(32), .Depth(STACK_DEPTH)) u_stack_ram (
    .clk_i, .we_i(s_we), .addr_i(s_addr), .wdata_i(s_wdata), .rdata_o(s_rdata));
  swe_ram #(.Width(32), .Depth(DATA_DEPTH)) u_data_ram (
    .clk_i, .we_i(d_we), .addr_i(d_addr), .wdata_i(d_wdata), .rdata_o(d_rdata));
  swe_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(s_rdata), .divisor_i(top_q),
    .done_o(div_done), .quot_o(div_q), .rem_o(div_r));

  action_e act;
  logic [1:0] need;
  logic [CntW-1:0] cnt_m1, cnt_m2;
  logic in_range;
  logic ops_ok;
  assign act = action_e'(tok_q.action);
  assign cnt_m1 = cnt_q - CntW'(1);
  assign cnt_m2 = cnt_q - CntW'(2);
  assign in_range = !top_q[31] && ({1'b0, top_q} < 33'(DATA_DEPTH));
  assign ops_ok = CntW'(need) <= cnt_q;

  always_comb begin
    unique case (act)
      ACT_NEG, ACT_FETCH, ACT_POP: need = 2'd1;
      ACT_PUSH_VAL, ACT_PUSH_VAR, ACT_NOP14, ACT_NOP15: need = 2'd0;
      default: need = 2'd2;
    endcase
  end

  assign token_i.ready = (state_q == S_IDLE) && !res_valid_q;
  assign result_o.valid = res_valid_q;
  assign result_o.payload = res_q;

  logic [31:0] alu;
  logic [63:0] prod;
  assign prod = s_rdata * top_q;
  always_comb begin
    unique case (act)
      ACT_ADD:     alu = s_rdata + top_q;
      ACT_SUB:     alu = s_rdata - top_q;
      ACT_MUL:     alu = prod[31:0];
      ACT_LESS:    alu = {31'd0, $signed(s_rdata) < $signed(top_q)};
      ACT_EQUAL:   alu = {31'd0, s_rdata == top_q};
      ACT_GREATER: alu = {31'd0, $signed(s_rdata) > $signed(top_q)};
      ACT_NEG:     alu = 32'd0 - top_q;
      default:     alu = 32'd0;
    endcase
  end

  always_comb begin
    s_we = 1'b0; s_addr = cnt_m1[SaW-1:0]; s_wdata = alu;
    d_we = 1'b0; d_addr = top_q[DaW-1:0]; d_wdata = s_rdata;
    div_start = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        d_we = 1'b1; d_addr = clr_q[DaW-1:0]; d_wdata = 32'd0;
      end
      S_RD_TOP: s_addr = cnt_m1[SaW-1:0];
      S_RD_SEC: s_addr = cnt_m2[SaW-1:0];
      S_EXEC: begin
        if (ops_ok) begin
          unique case (act)
            ACT_PUSH_VAL: begin
              s_we = cnt_q < CntW'(STACK_DEPTH); s_addr = cnt_q[SaW-1:0];
              s_wdata = tok_q.value;
            end
            ACT_PUSH_VAR: begin
              s_we = cnt_q < CntW'(STACK_DEPTH); s_addr = cnt_q[SaW-1:0];
              s_wdata = 32'(tok_q.letter) + 32'(tok_q.frame_offset);
            end
            ACT_NEG: s_we = 1'b1;
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_LESS, ACT_EQUAL, ACT_GREATER: begin
              s_we = 1'b1; s_addr = cnt_m2[SaW-1:0];
            end
            ACT_DIV, ACT_REM: div_start = (top_q != 32'd0);
            ACT_STORE: d_we = in_range;
            ACT_FETCH: s_we = !in_range;
            default: ;
          endcase
        end
      end
      S_DIV: begin
        s_addr = cnt_m1[SaW-1:0];
        s_we = div_done;
        s_wdata = (act == ACT_DIV) ? div_q : div_r;
      end
      S_FETCH: begin
        s_we = 1'b1; s_wdata = d_rdata;
      end
      default: ;
    endcase
  end

  result_t         exec_res;
  logic [CntW-1:0] exec_cnt;
  state_e          exec_next;

  always_comb begin
    exec_res = '0;
    exec_res.error_code = ERR_NONE;
    exec_res.stack_depth = 7'(cnt_q);
    exec_cnt = cnt_q;
    exec_next = S_DONE;
    if (act == ACT_NOP14 || act == ACT_NOP15) begin
    end else if (!ops_ok) begin
      exec_res.error_code = ERR_UNDER;
    end else begin
      unique case (act)
        ACT_PUSH_VAL, ACT_PUSH_VAR: begin
          if (cnt_q < CntW'(STACK_DEPTH)) begin
            exec_cnt = cnt_q + CntW'(1);
            exec_res.stack_depth = 7'(cnt_q + CntW'(1));
          end else begin
            exec_res.error_code = ERR_OVER;
          end
        end
        ACT_NEG: ;
        ACT_FETCH: begin
          if (!in_range) exec_res.error_code = ERR_ADDR;
          else exec_next = S_FETCH;
        end
        ACT_POP: begin
          exec_cnt = cnt_m1;
          exec_res.popped_value = top_q;
          exec_res.popped_valid = 1'b1;
          exec_res.stack_depth = 7'(cnt_m1);
        end
        ACT_STORE: begin
          exec_cnt = cnt_m2;
          exec_res.stack_depth = 7'(cnt_m2);
          if (!in_range) exec_res.error_code = ERR_ADDR;
        end
        ACT_DIV, ACT_REM: begin
          exec_cnt = cnt_m1;
          exec_res.stack_depth = 7'(cnt_m1);
          if (top_q == 32'd0)
            exec_res.error_code = (act == ACT_DIV) ? ERR_DIVZ : ERR_REMZ;
          else exec_next = S_DIV;
        end
        default: begin
          exec_cnt = cnt_m1;
          exec_res.stack_depth = 7'(cnt_m1);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      cnt_q <= '0;
      res_valid_q <= 1'b0;
      tok_q <= '0;
      top_q <= '0;
      res_q <= '0;
    end else begin
      if (result_o.valid && result_o.ready) res_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + (DaW+1)'(1);
          if (clr_q == (DaW+1)'(DATA_DEPTH - 1)) state_q <= S_IDLE;
        end
        S_IDLE: if (token_i.valid && token_i.ready) begin
          tok_q <= token_i.payload;
          state_q <= S_RD_TOP;
        end
        S_RD_TOP: state_q <= S_RD_SEC;
        S_RD_SEC: begin
          top_q <= s_rdata;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          res_q <= exec_res;
          cnt_q <= exec_cnt;
          state_q <= exec_next;
        end
        S_DIV: if (div_done) state_q <= S_DONE;
        S_FETCH: state_q <= S_DONE;
        S_DONE: begin
          res_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    token_i.valid && token_i.ready |=> !res_valid_q) else $error("result while taking item");
  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q == S_DONE)) else $error("result without done");
  a_depth_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> res_q.stack_depth == 7'(cnt_q)) else $error("reported depth mismatch");
endmodule

FILE: sim/testbench.sv
// Self-checking testbench of the stack word evaluator: token stream in, result items checked.
`timescale 1ns / 1ps
module testbench;
  import swe_pkg::*;

  localparam int unsigned StackMax = 64;
  localparam int unsigned DataMax  = 1024;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count = 0;
  int   result_count = 0;
  int   token_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off = 1'b0;

  swe_token_if  tok_if ();
  swe_result_if res_if ();

  stack_word_evaluator_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .token_i (tok_if.sink),
    .result_o(res_if.source)
  );

  always #5 clk_i = ~clk_i;

  logic [31:0] model_stack [StackMax];
  logic [31:0] model_mem [DataMax];
  int unsigned model_count;
  result_t     expected_results [$];

  initial begin
    tok_if.valid = 1'b0;
    tok_if.payload = '0;
    res_if.ready = 1'b0;
  end

  function automatic bit addr_ok(logic [31:0] a, output int unsigned idx);
    idx = a;
    return !a[31] && (a < DataMax);
  endfunction

  function automatic result_t evaluate_token(token_t t);
    result_t     r;
    int unsigned need;
    int unsigned idx;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] q;
    r = '0;
    need = 0;
    if (t.action == ACT_NEG || t.action == ACT_FETCH || t.action == ACT_POP) need = 1;
    else if (t.action >= ACT_ADD && t.action <= ACT_GREATER) need = 2;
    if (t.action > ACT_POP) begin
    end else if (model_count < need) begin
      r.error_code = ERR_UNDER;
    end else if (t.action == ACT_PUSH_VAL || t.action == ACT_PUSH_VAR) begin
      if (model_count >= StackMax) begin
        r.error_code = ERR_OVER;
      end else begin
        model_stack[model_count] = (t.action == ACT_PUSH_VAL) ? t.value :
            32'(t.letter) + 32'(t.frame_offset);
        model_count++;
      end
    end else if (need == 1) begin
      b = model_stack[model_count-1];
      case (t.action)
        ACT_NEG: model_stack[model_count-1] = -b;
        ACT_FETCH: begin
          if (addr_ok(b, idx)) model_stack[model_count-1] = model_mem[idx];
          else begin
            model_stack[model_count-1] = '0;
            r.error_code = ERR_ADDR;
          end
        end
        default: begin
          r.popped_value = b;
          r.popped_valid = 1'b1;
          model_count--;
        end
      endcase
    end else begin
      b = model_stack[model_count-1];
      a = model_stack[model_count-2];
      q = '0;
      case (t.action)
        ACT_ADD: q = a + b;
        ACT_SUB: q = a - b;
        ACT_MUL: q = a * b;
        ACT_LESS: q = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        ACT_EQUAL: q = (a == b) ? 32'd1 : 32'd0;
        ACT_GREATER: q = ($signed(a) > $signed(b)) ? 32'd1 : 32'd0;
        ACT_DIV, ACT_REM: begin
          if (b == 0) begin
          end else if (a == 32'h8000_0000 && b == 32'hffff_ffff) begin
            q = (t.action == ACT_DIV) ? a : 32'd0;
          end else begin
            q = (t.action == ACT_DIV) ? $signed(a) / $signed(b) : $signed(a) % $signed(b);
          end
        end
        default: ;
      endcase
      if ((t.action == ACT_DIV || t.action == ACT_REM) && b == 0) begin
        r.error_code = (t.action == ACT_DIV) ? ERR_DIVZ : ERR_REMZ;
        model_count--;
      end else if (t.action == ACT_STORE) begin
        if (addr_ok(b, idx)) model_mem[idx] = a;
        else r.error_code = ERR_ADDR;
        model_count -= 2;
      end else begin
        model_count--;
        model_stack[model_count-1] = q;
      end
    end
    r.stack_depth = 7'(model_count);
    return r;
  endfunction

  task automatic send_token(action_e act, logic [31:0] val = '0, logic [4:0] let_idx = '0,
                            logic [9:0] offs = '0);
    token_t t;
    t.action = act;
    t.value = val;
    t.letter = let_idx;
    t.frame_offset = offs;
    while ($urandom_range(99) < send_idle_pct) begin
      tok_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tok_if.valid <= 1'b1;
    tok_if.payload <= t;
    @(posedge clk_i);
    while (!tok_if.ready) @(posedge clk_i);
    expected_results.push_back(evaluate_token(t));
    token_count++;
  endtask

  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) begin
      result_count++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, res_if.payload);
        fail_count++;
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (res_if.payload.popped_value !== e.popped_value ||
            res_if.payload.popped_valid !== e.popped_valid ||
            res_if.payload.error_code !== e.error_code ||
            res_if.payload.stack_depth !== e.stack_depth) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, res_if.payload);
          fail_count++;
        end
      end
    end
    res_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic drain;
    tok_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'(($urandom_range(40)) - 20);
      4: return $urandom_range(DataMax + 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed;
    send_token(ACT_POP);
    send_token(ACT_ADD);
    send_token(ACT_PUSH_VAL, 32'h8000_0000);
    send_token(ACT_NEG);
    send_token(ACT_PUSH_VAL, 32'hffff_ffff);
    send_token(ACT_DIV);
    send_token(ACT_PUSH_VAL, 32'hffff_ffff);
    send_token(ACT_REM);
    send_token(ACT_PUSH_VAL, 0);
    send_token(ACT_DIV);
    send_token(ACT_PUSH_VAL, 0);
    send_token(ACT_REM);
    send_token(ACT_PUSH_VAL, 32'h7fff_ffff);
    send_token(ACT_PUSH_VAR, 0, 5'd31, 10'h3ff);
    send_token(ACT_STORE);
    send_token(ACT_PUSH_VAR, 0, 5'd25, 10'd998);
    send_token(ACT_FETCH);
    send_token(ACT_PUSH_VAL, 32'hffff_ffff);
    send_token(ACT_FETCH);
    send_token(ACT_NOP14);
    send_token(ACT_NOP15);
    send_token(ACT_MUL);
    send_token(ACT_POP);
    drain();
  endtask

  task automatic test_random(int n);
    action_e act;
    repeat (n) begin
      if (model_count < 3 || $urandom_range(3) == 0)
        act = ($urandom_range(1) != 0) ? ACT_PUSH_VAL : ACT_PUSH_VAR;
      else act = action_e'($urandom_range(15));
      send_token(act, pick_value(), 5'($urandom), 10'($urandom));
    end
    drain();
  endtask

  task automatic test_overflow;
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (StackMax + 4) send_token(ACT_PUSH_VAL, $urandom);
    join
    drain();
    repeat (StackMax + 2) send_token(ACT_POP);
    drain();
  endtask

  initial begin
    foreach (model_mem[i]) model_mem[i] = '0;
    model_count = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_overflow();
    test_random(100);
    send_idle_pct = 85;
    test_random(130);
    send_idle_pct = 0;
    recv_stall_pct = 85;
    test_random(130);
    send_idle_pct = 28;
    recv_stall_pct = 28;
    test_random(130);
    repeat (60) @(posedge clk_i);
    $display("Sent %0d tokens, checked %0d results: all actions, stack limits,",
             token_count, result_count);
    $display("division corner cases, address range errors and handshake stalls.");
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("PASS stack_word_evaluator_top");
    end else begin
      $display("FAIL stack_word_evaluator_top");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL stack_word_evaluator_top");
    $finish;
  end
endmodule

FILE: filelist.f
hdl/swe_pkg.sv
hdl/swe_token_if.sv
hdl/swe_result_if.sv
hdl/swe_ram.sv
hdl/swe_divider.sv
hdl/stack_word_evaluator_top.sv
sim/testbench.sv
